FILE: hdl/pfs_pkg.sv
// ----------------------------------------------------------------------------
// pfs_pkg
// Shared types and constants of the preamble correlation frame sync block.
// ----------------------------------------------------------------------------
package pfs_pkg;

   localparam int BITS_W      = 64;   // preamble bit register
   localparam int BIT_IDX_W   = 6;    // index into preamble bit register
   localparam int LEN_W       = 7;    // preamble length register
   localparam int THR_W       = 16;   // threshold register
   localparam int POS_W       = 32;   // symbol position
   localparam int CSR_IDX_W   = 8;    // register index on the write channel
   localparam int CSR_DATA_W  = 64;
   localparam int NORM_SHIFT  = 30;   // Q1.15 squared scale
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_PREAMBLE_BITS = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PREAMBLE_LEN  = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD     = 8'd2;

   localparam logic [LEN_W-1:0] LEN_RESET = 7'd32;
   localparam logic [THR_W-1:0] THR_RESET = 16'd26214;

   typedef struct packed {
      logic [BITS_W-1:0] bits;
      logic [LEN_W-1:0]  len;   // effective length, 1..MAX_PREAMBLE
      logic [THR_W-1:0]  thr;
   } cfg_type;

   typedef struct packed {
      logic busy;    // a window test is in progress
      logic found;   // a hit was reported since the last restart
   } back_stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DRAIN,
      ST_SQUARE,
      ST_SCALE,
      ST_PROD,
      ST_COMPARE
   } back_state_type;

endpackage

FILE: hdl/pfs_if.sv
// ----------------------------------------------------------------------------
// pfs channel interfaces
// Symbol input, result output and register write channels.
// ----------------------------------------------------------------------------
interface pfs_req_if #(parameter int SAMPLE_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_i;
   logic signed [SAMPLE_BITS-1:0] sample_q;
   logic                          restart;

   modport source (output valid, sample_i, sample_q, restart, input ready);
   modport sink   (input valid, sample_i, sample_q, restart, output ready);
endinterface

interface pfs_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit;
   logic [31:0] position;

   modport source (output valid, hit, position, input ready);
   modport sink   (input valid, hit, position, output ready);
endinterface

interface pfs_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [63:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/pfs_ram.sv
// ----------------------------------------------------------------------------
// pfs_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pfs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

FILE: hdl/pfs_queue.sv
// ----------------------------------------------------------------------------
// pfs_queue
// Short FIFO between the intake and the correlator.
// ----------------------------------------------------------------------------
module pfs_queue #(
   parameter int WIDTH = 66
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty
);
   import pfs_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] data_ff [QUEUE_DEPTH];
   logic [PW-1:0]    head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0]    count_ff, count_in;

   assign full      = (count_ff == CW'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = data_ff[head_ff];

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = (tail_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
      if (pop) begin
         head_in = (head_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
      if (push) begin
         data_ff[tail_ff] <= push_data;
      end
   end
endmodule

FILE: hdl/pfs_front.sv
// ----------------------------------------------------------------------------
// pfs_front
// Symbol intake: keeps the position count and flags windows due for a test.
// ----------------------------------------------------------------------------
module pfs_front #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   pfs_req_if.sink                       req_if,
   input  logic [pfs_pkg::LEN_W-1:0]     len_eff,
   input  logic                          q_full,
   output logic                          q_push,
   output logic [2*SAMPLE_BITS+pfs_pkg::POS_W+1:0] q_data
);
   import pfs_pkg::*;

   logic [POS_W-1:0] count_ff, count_in;
   logic             eligible;

   assign req_if.ready = !q_full;
   assign q_push       = req_if.valid && !q_full;

   always_comb begin
      if (req_if.restart) begin
         count_in = POS_W'(1);
      end else if (count_ff == '1) begin
         count_in = count_ff;
      end else begin
         count_in = count_ff + 1'b1;
      end
   end

   // enough symbols since restart to fill the window
   assign eligible = (count_in >= POS_W'(len_eff));

   assign q_data = {req_if.sample_i, req_if.sample_q, count_in, req_if.restart, eligible};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (q_push) begin
         count_ff <= count_in;
      end
   end
endmodule

FILE: hdl/pfs_back.sv
// ----------------------------------------------------------------------------
// pfs_back
// Correlator: stores symbols in the window RAM, sums correlation and energy
// over the window one symbol a cycle, then runs the normalized test.
// ----------------------------------------------------------------------------
module pfs_back #(
   parameter int MAX_PREAMBLE = 64,
   parameter int SAMPLE_BITS  = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  pfs_pkg::cfg_type                       cfg,
   input  logic                                   q_not_empty,
   input  logic [2*SAMPLE_BITS+pfs_pkg::POS_W+1:0] q_data,
   output logic                                   q_pop,
   pfs_rsp_if.source                              rsp_if,
   output pfs_pkg::back_stat_type                 stat
);
   import pfs_pkg::*;

   localparam int SB   = SAMPLE_BITS;
   localparam int AW   = $clog2(MAX_PREAMBLE);
   localparam int GW   = $clog2(MAX_PREAMBLE + 1);
   localparam int CB   = SB + GW;            // correlation sum
   localparam int EB   = 2 * SB + GW;        // energy sum
   localparam int EL   = EB / 2;
   localparam int EH   = EB - EL;
   localparam int SQB  = 2 * CB;
   localparam int CSB  = SQB + 1;
   localparam int TSB  = 2 * THR_W;
   localparam int TW   = TSB + LEN_W;
   localparam int LB   = CSB + NORM_SHIFT;
   localparam int RB   = TW + EB;
   localparam int CMPW = (LB > RB) ? LB : RB;
   localparam int DW   = ((AW > LEN_W) ? AW : LEN_W) + 1;

   back_state_type state_ff, state_in;

   // queue entry fields
   logic signed [SB-1:0] e_i, e_q;
   logic [POS_W-1:0]     e_count;
   logic                 e_restart, e_eligible;
   assign {e_i, e_q, e_count, e_restart, e_eligible} = q_data;

   logic [AW-1:0]      wptr_ff, wptr_in, rd_addr_ff, rd_addr_in, start_addr;
   logic [LEN_W-1:0]   rd_idx_ff, rd_idx_in;
   logic               acc_vld_ff, acc_vld_in, acc_neg_ff, acc_neg_in;
   logic signed [CB-1:0] ci_ff, ci_in, cq_ff, cq_in;
   logic [EB-1:0]      e_ff, e_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               found_ff, found_in;
   logic [SQB-1:0]     sqi_ff, sqi_in, sqq_ff, sqq_in;
   logic [TSB-1:0]     tsq_ff, tsq_in;
   logic [CSB-1:0]     cs_ff, cs_in;
   logic [TW-1:0]      tl_ff, tl_in;
   logic [TW+EL-1:0]   plo_ff, plo_in;
   logic [TW+EH-1:0]   phi_ff, phi_in;
   logic               out_vld_ff, out_vld_in, out_hit_ff, out_hit_in;
   logic [POS_W-1:0]   out_pos_ff, out_pos_in;

   logic               pop, test, last_read, hit;
   logic [2*SB-1:0]    ram_rdata;
   logic signed [SB-1:0] rd_i, rd_q;
   logic signed [2*SB-1:0] pi, pq;
   logic signed [CB-1:0] si, sq;
   logic [CB-1:0]      ai, aq;
   logic [DW-1:0]      w_ext, lm1;
   logic [CMPW-1:0]    lhs, rhs;

   pfs_ram #(
      .WIDTH (2 * SB),
      .DEPTH (MAX_PREAMBLE)
   ) u_window (
      .clock (clock),
      .we    (pop),
      .waddr (wptr_ff),
      .wdata ({e_i, e_q}),
      .raddr (rd_addr_ff),
      .rdata (ram_rdata)
   );

   assign pop   = (state_ff == ST_IDLE) && q_not_empty && (!out_vld_ff || rsp_if.ready);
   assign q_pop = pop;
   // a restart clears found before this symbol is tested
   assign test  = e_eligible && (e_restart || !found_ff);
   assign last_read = (rd_idx_ff == cfg.len - 1'b1);

   // oldest symbol of the window: newest address minus (len - 1), wrapped
   always_comb begin
      w_ext = DW'(wptr_ff);
      lm1   = DW'(cfg.len - 1'b1);
      if (w_ext >= lm1) begin
         start_addr = AW'(w_ext - lm1);
      end else begin
         start_addr = AW'(w_ext + DW'(MAX_PREAMBLE) - lm1);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (pop && test) state_in = ST_READ;
         ST_READ:    if (last_read) state_in = ST_DRAIN;
         ST_DRAIN:   state_in = ST_SQUARE;
         ST_SQUARE:  state_in = ST_SCALE;
         ST_SCALE:   state_in = ST_PROD;
         ST_PROD:    state_in = ST_COMPARE;
         ST_COMPARE: state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   assign {rd_i, rd_q} = ram_rdata;
   assign pi = rd_i * rd_i;
   assign pq = rd_q * rd_q;
   assign si = CB'(rd_i);
   assign sq = CB'(rd_q);
   assign ai = ci_ff[CB-1] ? CB'(-ci_ff) : CB'(ci_ff);
   assign aq = cq_ff[CB-1] ? CB'(-cq_ff) : CB'(cq_ff);

   assign lhs = CMPW'(cs_ff) << NORM_SHIFT;
   assign rhs = (CMPW'(phi_ff) << EL) + CMPW'(plo_ff);
   assign hit = (e_ff != '0) && (lhs >= rhs);

   // datapath and outputs
   always_comb begin
      wptr_in    = wptr_ff;
      rd_addr_in = rd_addr_ff;
      rd_idx_in  = rd_idx_ff;
      acc_vld_in = 1'b0;
      acc_neg_in = acc_neg_ff;
      ci_in      = ci_ff;
      cq_in      = cq_ff;
      e_in       = e_ff;
      pos_in     = pos_ff;
      found_in   = found_ff;
      sqi_in     = sqi_ff;
      sqq_in     = sqq_ff;
      tsq_in     = tsq_ff;
      cs_in      = cs_ff;
      tl_in      = tl_ff;
      plo_in     = plo_ff;
      phi_in     = phi_ff;
      out_vld_in = out_vld_ff && !rsp_if.ready;
      out_hit_in = out_hit_ff;
      out_pos_in = out_pos_ff;

      // one window symbol a beat, in the cycle after its read
      if (acc_vld_ff) begin
         ci_in = acc_neg_ff ? ci_ff - si : ci_ff + si;
         cq_in = acc_neg_ff ? cq_ff - sq : cq_ff + sq;
         e_in  = e_ff + EB'(unsigned'(pi)) + EB'(unsigned'(pq));
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               wptr_in = (wptr_ff == AW'(MAX_PREAMBLE - 1)) ? '0 : wptr_ff + 1'b1;
               if (e_restart) begin
                  found_in = 1'b0;
               end
               pos_in = e_count;
               if (test) begin
                  rd_addr_in = start_addr;
                  rd_idx_in  = '0;
                  ci_in      = '0;
                  cq_in      = '0;
                  e_in       = '0;
               end else begin
                  out_vld_in = 1'b1;
                  out_hit_in = 1'b0;
                  out_pos_in = e_count;
               end
            end
         end
         ST_READ: begin
            rd_addr_in = (rd_addr_ff == AW'(MAX_PREAMBLE - 1)) ? '0 : rd_addr_ff + 1'b1;
            rd_idx_in  = rd_idx_ff + 1'b1;
            acc_vld_in = 1'b1;
            acc_neg_in = cfg.bits[rd_idx_ff[BIT_IDX_W-1:0]];
         end
         ST_DRAIN: begin
         end
         ST_SQUARE: begin
            sqi_in = ai * ai;
            sqq_in = aq * aq;
            tsq_in = cfg.thr * cfg.thr;
         end
         ST_SCALE: begin
            cs_in = CSB'(sqi_ff) + CSB'(sqq_ff);
            tl_in = tsq_ff * cfg.len;
         end
         ST_PROD: begin
            plo_in = tl_ff * e_ff[EL-1:0];
            phi_in = tl_ff * e_ff[EB-1:EL];
         end
         ST_COMPARE: begin
            out_vld_in = 1'b1;
            out_hit_in = hit;
            out_pos_in = pos_ff;
            if (hit) begin
               found_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         wptr_ff    <= '0;
         acc_vld_ff <= 1'b0;
         found_ff   <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         wptr_ff    <= wptr_in;
         acc_vld_ff <= acc_vld_in;
         found_ff   <= found_in;
         out_vld_ff <= out_vld_in;
      end
      rd_addr_ff <= rd_addr_in;
      rd_idx_ff  <= rd_idx_in;
      acc_neg_ff <= acc_neg_in;
      ci_ff      <= ci_in;
      cq_ff      <= cq_in;
      e_ff       <= e_in;
      pos_ff     <= pos_in;
      sqi_ff     <= sqi_in;
      sqq_ff     <= sqq_in;
      tsq_ff     <= tsq_in;
      cs_ff      <= cs_in;
      tl_ff      <= tl_in;
      plo_ff     <= plo_in;
      phi_ff     <= phi_in;
      out_hit_ff <= out_hit_in;
      out_pos_ff <= out_pos_in;
   end

   assign rsp_if.valid    = out_vld_ff;
   assign rsp_if.hit      = out_hit_ff;
   assign rsp_if.position = out_pos_ff;

   assign stat.busy  = (state_ff != ST_IDLE);
   assign stat.found = found_ff;
endmodule

FILE: hdl/preamble_correlation_frame_sync.sv
// ----------------------------------------------------------------------------
// preamble_correlation_frame_sync
// Normalized cross-correlation preamble detector with register port.
// ----------------------------------------------------------------------------
// One result beat per symbol beat. A symbol whose window is not tested (too
// few symbols since restart, or a hit already reported) gets its result from
// the idle state. For a tested window the window RAM has one read port, so
// correlation and energy are summed one stored symbol a cycle, followed by the
// drain, squaring, scaling, product and compare steps of the test. The intake
// takes symbols into a two-beat queue while the correlator works. The
// correlator takes its next symbol only once the result register is empty or
// its beat is being taken in that cycle.
// ----------------------------------------------------------------------------
module preamble_correlation_frame_sync #(
   parameter int MAX_PREAMBLE = 64,
   parameter int SAMPLE_BITS  = 16
) (
   input  logic     clock,
   input  logic     reset,
   pfs_req_if.sink  req_if,
   pfs_rsp_if.source rsp_if,
   pfs_csr_if.sink  csr_if
);
   import pfs_pkg::*;

   localparam int QW = 2 * SAMPLE_BITS + POS_W + 2;

   logic [BITS_W-1:0] bits_ff;
   logic [LEN_W-1:0]  len_ff, len_eff;
   logic [THR_W-1:0]  thr_ff;
   cfg_type           cfg;
   back_stat_type     stat;

   logic          q_push, q_pop, q_full, q_not_empty;
   logic [QW-1:0] q_wdata, q_rdata;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff <= '0;
         len_ff  <= LEN_RESET;
         thr_ff  <= THR_RESET;
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_PREAMBLE_BITS: bits_ff <= csr_if.data;
            CSR_PREAMBLE_LEN:  len_ff  <= csr_if.data[LEN_W-1:0];
            CSR_THRESHOLD:     thr_ff  <= csr_if.data[THR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // zero length acts as one, lengths past the window clamp to it
   always_comb begin
      if (len_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (len_ff > LEN_W'(MAX_PREAMBLE)) begin
         len_eff = LEN_W'(MAX_PREAMBLE);
      end else begin
         len_eff = len_ff;
      end
   end

   assign cfg.bits = bits_ff;
   assign cfg.len  = len_eff;
   assign cfg.thr  = thr_ff;

   pfs_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .len_eff (len_eff),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_data  (q_wdata)
   );

   pfs_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .not_empty (q_not_empty)
   );

   pfs_back #(
      .MAX_PREAMBLE (MAX_PREAMBLE),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .q_not_empty (q_not_empty),
      .q_data      (q_rdata),
      .q_pop       (q_pop),
      .rsp_if      (rsp_if),
      .stat        (stat)
   );

   // a hit needs a full window behind it
   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.hit |-> rsp_if.position >= POS_W'(len_eff))
      else $error("hit reported before window filled");

   // the result register is empty for the whole window test
   assert property (@(posedge clock) disable iff (reset)
      stat.busy |-> !rsp_if.valid)
      else $error("result pending during window test");

   // a hit on the output is always backed by the found flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.hit |-> stat.found)
      else $error("hit shown without found flag");
endmodule

FILE: sim/tb_preamble_correlation_frame_sync.sv
// ----------------------------------------------------------------------------
// tb_preamble_correlation_frame_sync
// Self-checking bench for the preamble correlation frame sync block. Symbols
// go in as BPSK preambles buried in noise, pure noise, zero windows and
// full-scale values. Every result beat is compared with a bit-exact software
// detector that runs on each accepted symbol beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_preamble_correlation_frame_sync;
   import pfs_pkg::*;

   localparam int MAX_PREAMBLE = 64;
   localparam int SAMPLE_BITS  = 16;

   typedef struct {
      logic             hit;
      logic [POS_W-1:0] position;
   } sync_result_type;

   // Software copy of the detector, plus the queue of results still due.
   class frame_sync_scoreboard_type;
      logic [BITS_W-1:0]                pre_bits;
      logic [LEN_W-1:0]                 pre_len;
      logic [THR_W-1:0]                 thr;
      logic signed [SAMPLE_BITS-1:0]    win_i [MAX_PREAMBLE];
      logic signed [SAMPLE_BITS-1:0]    win_q [MAX_PREAMBLE];
      logic [37:0]                      win_energy;
      logic [POS_W-1:0]                 sym_count;
      bit                               found;
      sync_result_type                  due_q [$];
      int                               errors;

      function new();
         pre_bits = '0;
         pre_len  = LEN_RESET;
         thr      = THR_RESET;
         errors   = 0;
         clear_run();
      endfunction

      function void clear_run();
         for (int k = 0; k < MAX_PREAMBLE; k++) begin
            win_i[k] = '0;
            win_q[k] = '0;
         end
         win_energy = '0;
         sym_count  = '0;
         found      = 0;
      endfunction

      function int unsigned span();
         int unsigned l;
         l = pre_len;
         if (l == 0) l = 1;
         if (l > MAX_PREAMBLE) l = MAX_PREAMBLE;
         return l;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_PREAMBLE_BITS: pre_bits = data;
            CSR_PREAMBLE_LEN:  pre_len  = data[LEN_W-1:0];
            CSR_THRESHOLD:     thr      = data[THR_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_symbol(logic signed [SAMPLE_BITS-1:0] si_in,
                                logic signed [SAMPLE_BITS-1:0] sq_in, bit rs);
         int unsigned  len;
         int unsigned  idx;
         longint       ci, cq, si, sq;
         logic [63:0]  e, ai, aq, cs;
         logic [127:0] lhs, rhs, t;
         sync_result_type r;
         len = span();
         if (rs) clear_run();
         for (int k = MAX_PREAMBLE - 1; k > 0; k--) begin
            win_i[k] = win_i[k-1];
            win_q[k] = win_q[k-1];
         end
         win_i[0] = si_in;
         win_q[0] = sq_in;
         if (sym_count != '1) sym_count++;
         r.hit = 0;
         if (!found && sym_count >= len) begin
            ci = 0;
            cq = 0;
            e  = '0;
            // preamble symbol j lines up with the j-th oldest of the span
            for (int unsigned j = 0; j < len; j++) begin
               idx = (len - 1 - j) & (MAX_PREAMBLE - 1);
               si  = longint'(win_i[idx]);
               sq  = longint'(win_q[idx]);
               if (pre_bits[j]) begin
                  ci -= si;
                  cq -= sq;
               end else begin
                  ci += si;
                  cq += sq;
               end
               e += 64'(si * si) + 64'(sq * sq);
            end
            win_energy = e[37:0];
            if (e != 0) begin
               ai  = (ci < 0) ? 64'(-ci) : 64'(ci);
               aq  = (cq < 0) ? 64'(-cq) : 64'(cq);
               cs  = ai * ai + aq * aq;
               lhs = 128'(cs) << NORM_SHIFT;
               t   = 128'(thr) * 128'(thr) * 128'(len);
               rhs = t * 128'(e);
               if (lhs >= rhs) begin
                  r.hit = 1;
                  found = 1;
               end
            end
         end
         r.position = sym_count;
         due_q.push_back(r);
      endfunction

      function void check_result(logic hit, logic [POS_W-1:0] position);
         sync_result_type exp_r;
         if (due_q.size() == 0) begin
            $error("result beat with nothing due: hit %0d position %0d", hit, position);
            errors++;
            return;
         end
         exp_r = due_q.pop_front();
         if (hit !== exp_r.hit) begin
            $error("hit mismatch: expected %0d actual %0d", exp_r.hit, hit);
            errors++;
         end
         if (position !== exp_r.position) begin
            $error("position mismatch: expected %0d actual %0d", exp_r.position, position);
            errors++;
         end
      endfunction

      function int pending();
         return due_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   steady;          // no idling on either side while set
   int   results_seen;
   int   random_sent;
   frame_sync_scoreboard_type sb;

   pfs_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_bus ();
   pfs_rsp_if rsp_bus ();
   pfs_csr_if csr_bus ();

   preamble_correlation_frame_sync #(
      .MAX_PREAMBLE (MAX_PREAMBLE),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   always #6 clock = ~clock;

   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // Result side: random back-pressure plus one long hold-off to fill the block.
   initial begin
      int  hold_left;
      bit  held;
      hold_left = 0;
      held      = 0;
      rsp_bus.ready = 0;
      forever begin
         @(negedge clock);
         if (!held && results_seen >= 300) begin
            held      = 1;
            hold_left = 400;
         end
         if (reset) begin
            rsp_bus.ready = 0;
         end else if (hold_left > 0) begin
            rsp_bus.ready = 0;
            hold_left--;
         end else begin
            rsp_bus.ready = steady || ($urandom_range(99) >= 11);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         sb.check_result(rsp_bus.hit, rsp_bus.position);
         results_seen++;
      end
   end

   function automatic logic signed [SAMPLE_BITS-1:0] clip(int v);
      if (v > 32767) return 16'sd32767;
      if (v < -32768) return -16'sd32768;
      return SAMPLE_BITS'(v);
   endfunction

   // Entered and left at a falling edge; valid stays high after the beat.
   task automatic send_symbol(logic signed [SAMPLE_BITS-1:0] si,
                              logic signed [SAMPLE_BITS-1:0] sq, bit rs);
      if (!steady && $urandom_range(99) < 11) begin
         req_bus.valid = 0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_bus.valid    = 1;
      req_bus.sample_i = si;
      req_bus.sample_q = sq;
      req_bus.restart  = rs;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_symbol(si, sq, rs);
      @(negedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_bus.valid = 1;
      csr_bus.index = idx;
      csr_bus.data  = data;
      do @(posedge clock); while (!csr_bus.ready);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_bus.valid = 0;
   endtask

   task automatic drain();
      req_bus.valid = 0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // A restart (most of the time), some noise, the preamble at a random gain with noise, a short tail.
   task automatic run_frame(int unsigned len, logic [BITS_W-1:0] bits);
      int amp, ns, lead, tail;
      bit rs;
      amp  = $urandom_range(200, 40000);
      ns   = amp >> $urandom_range(1, 6);
      lead = $urandom_range(0, 6);
      tail = $urandom_range(0, 5);
      rs   = ($urandom_range(9) != 0);
      for (int k = 0; k < lead; k++) begin
         send_symbol(clip(int'($urandom_range(0, 2 * ns)) - ns),
                     clip(int'($urandom_range(0, 2 * ns)) - ns), rs && k == 0);
         random_sent++;
      end
      for (int unsigned j = 0; j < len; j++) begin
         send_symbol(clip((bits[j] ? -amp : amp) + int'($urandom_range(0, 2 * ns)) - ns),
                     clip(int'($urandom_range(0, 2 * ns)) - ns), rs && lead == 0 && j == 0);
         random_sent++;
      end
      for (int k = 0; k < tail; k++) begin
         send_symbol(clip(int'($urandom_range(0, 2 * ns)) - ns),
                     clip(int'($urandom_range(0, 2 * ns)) - ns), 1'b0);
         random_sent++;
      end
   endtask

   initial begin
      logic [BITS_W-1:0] bits;
      logic [LEN_W-1:0]  len_val;
      logic [THR_W-1:0]  thr_val;
      int unsigned       eff;
      int                pick;
      clock = 0;
      reset = 1;
      steady = 0;
      results_seen = 0;
      random_sent  = 0;
      req_bus.valid    = 0;
      req_bus.sample_i = '0;
      req_bus.sample_q = '0;
      req_bus.restart  = 0;
      csr_bus.valid = 0;
      csr_bus.index = '0;
      csr_bus.data  = '0;
      sb = new();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // reset configuration, no restart since reset
      send_symbol(16'sd1000, -16'sd500, 1'b0);
      send_symbol(-16'sd32768, 16'sd32767, 1'b0);
      drain();
      // length zero acts as one; threshold zero hits any nonzero window
      write_register(CSR_PREAMBLE_LEN, 64'd0);
      write_register(CSR_THRESHOLD, 64'd0);
      write_register(CSR_PREAMBLE_BITS, 64'd0);
      send_symbol(16'sd5, 16'sd0, 1'b0);
      send_symbol(16'sd32767, 16'sd32767, 1'b0);    // already found
      send_symbol(16'sd0, 16'sd0, 1'b1);            // zero energy, skipped
      send_symbol(16'sd0, -16'sd1, 1'b0);
      drain();
      // threshold above one: never passes
      write_register(CSR_THRESHOLD, 64'd65535);
      write_register(CSR_PREAMBLE_BITS, '1);
      send_symbol(-16'sd32768, -16'sd32768, 1'b1);
      send_symbol(16'sd32767, 16'sd0, 1'b0);
      drain();
      // threshold exactly one: equality passes
      write_register(CSR_THRESHOLD, 64'd32768);
      send_symbol(-16'sd32768, 16'sd0, 1'b1);
      drain();
      write_register(CSR_PREAMBLE_LEN, 64'd2);
      write_register(CSR_THRESHOLD, 64'd29000);
      write_register(CSR_PREAMBLE_BITS, 64'h2);
      send_symbol(16'sd1000, 16'sd0, 1'b1);
      send_symbol(-16'sd3000, 16'sd0, 1'b0);
      drain();

      while (random_sent < 1300) begin
         pick = $urandom_range(99);
         if (pick < 10)      len_val = 7'd0;
         else if (pick < 20) len_val = LEN_W'($urandom_range(64, 127));
         else if (pick < 30) len_val = LEN_W'($urandom_range(13, 63));
         else                len_val = LEN_W'($urandom_range(1, 12));
         pick = $urandom_range(99);
         if (pick < 8)       thr_val = '0;
         else if (pick < 14) thr_val = 16'd32768;
         else if (pick < 18) thr_val = 16'hFFFF;
         else if (pick < 25) thr_val = THR_W'($urandom);
         else                thr_val = THR_W'($urandom_range(12000, 31000));
         pick = $urandom_range(99);
         if (pick < 5)       bits = '0;
         else if (pick < 10) bits = '1;
         else                bits = {$urandom, $urandom};
         write_register(CSR_PREAMBLE_BITS, bits);
         write_register(CSR_PREAMBLE_LEN, {57'($urandom), len_val});
         write_register(CSR_THRESHOLD, {48'($urandom), thr_val});
         eff = (len_val == 0) ? 1 : (len_val > MAX_PREAMBLE) ? MAX_PREAMBLE : len_val;
         steady = (random_sent >= 500 && random_sent < 800);
         repeat ((eff > 16) ? 2 : $urandom_range(2, 6)) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
               run_frame(eff, bits);
            end else if (pick < 90) begin
               // full-range noise with random restarts
               repeat ($urandom_range(1, 8)) begin
                  send_symbol(SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom),
                              $urandom_range(9) == 0);
                  random_sent++;
               end
            end else begin
               // dead air: zero windows are skipped
               repeat ($urandom_range(1, eff + 2)) begin
                  send_symbol(16'sd0, 16'sd0, 1'b0);
                  random_sent++;
               end
            end
         end
         drain();
      end

      steady = 0;
      req_bus.valid = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: preamble_correlation_frame_sync.f
hdl/pfs_pkg.sv
hdl/pfs_if.sv
hdl/pfs_ram.sv
hdl/pfs_queue.sv
hdl/pfs_front.sv
hdl/pfs_back.sv
hdl/preamble_correlation_frame_sync.sv
sim/tb_preamble_correlation_frame_sync.sv
